/* rtl/core/skt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared definitions for the sorted key table
// Field widths, operation and status codes, sequencer states and the
// compare result that passes between the modules of the block.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CapacityDef = 32;
  localparam int KeyBytesDef = 8;

  localparam int ActionWidth = 2;
  localparam int KeyWidth    = 64;
  localparam int StatusWidth = 2;
  localparam int PosWidth    = 5;
  localparam int CountWidth  = 6;

  localparam logic [ActionWidth-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionWidth-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ActionWidth-1:0] ACT_SEARCH = 2'd2;

  localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
  localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusWidth-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [StatusWidth-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_PLACE,
    S_DEL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

/* rtl/core/skt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/skt_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cmp: shared key comparator
// Compares a stored key against the key of the current word.
// ----------------------------------------------------------------------------
module skt_cmp #(
  parameter int Width = 64
) (
  input  logic [Width-1:0]       stored,
  input  logic [Width-1:0]       probe,
  output skt_pkg::cmp_res_t      res
);

  import skt_pkg::*;

  always_comb begin
    res.lt = (stored < probe);
    res.eq = (stored == probe);
  end

endmodule

/* rtl/core/skt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl: sequencer of the sorted key table
// Scans the table for the first key not below the probe, then for an insert
// or remove moves later entries one slot up or down, and reports the result.
// ----------------------------------------------------------------------------
module skt_ctrl #(
  parameter int Capacity = skt_pkg::CapacityDef,
  parameter int KeyBytes = skt_pkg::KeyBytesDef
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [skt_pkg::ActionWidth-1:0]     action,
  input  logic [skt_pkg::KeyWidth-1:0]        key,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [skt_pkg::StatusWidth-1:0]     status,
  output logic [skt_pkg::PosWidth-1:0]        position,
  output logic [skt_pkg::CountWidth-1:0]      entry_count,
  output logic                                ram_we,
  output logic [$clog2(Capacity)-1:0]         ram_waddr,
  output logic [8*KeyBytes-1:0]               ram_wdata,
  output logic [$clog2(Capacity)-1:0]         ram_raddr,
  input  logic [8*KeyBytes-1:0]               ram_rdata,
  output logic [8*KeyBytes-1:0]               probe,
  input  skt_pkg::cmp_res_t                   cmp_res
);

  import skt_pkg::*;

  localparam int KW = 8 * KeyBytes;
  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);

  state_t                 state, state_next;
  logic [CW-1:0]          cnt, cnt_next;
  logic [CW-1:0]          idx, idx_next;
  logic [CW-1:0]          pidx, pidx_next;
  logic [CW-1:0]          at, at_next;
  logic                   pv, pv_next;
  logic [KW-1:0]          key_r, key_next;
  logic [ActionWidth-1:0] act, act_next;
  logic [StatusWidth-1:0] st, st_next;
  logic [PosWidth-1:0]    pos, pos_next;
  logic                   rsp_valid_next;
  logic [StatusWidth-1:0] status_next;
  logic [PosWidth-1:0]    position_next;
  logic [CountWidth-1:0]  entry_count_next;
  logic [CW-1:0]          idx_inc, idx_dec;
  logic                   scan_end, scan_hit;
  logic [CW-1:0]          scan_at;

  assign probe   = key_r;
  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);

  assign scan_end = (pv && !cmp_res.lt) || (!pv && idx == cnt);
  assign scan_hit = pv && cmp_res.eq;
  assign scan_at  = pv ? pidx : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pv        <= pv_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    pidx        <= pidx_next;
    at          <= at_next;
    key_r       <= key_next;
    act         <= act_next;
    st          <= st_next;
    pos         <= pos_next;
    status      <= status_next;
    position    <= position_next;
    entry_count <= entry_count_next;
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    idx_next         = idx;
    pidx_next        = pidx;
    at_next          = at;
    pv_next          = 1'b0;
    key_next         = key_r;
    act_next         = act;
    st_next          = st;
    pos_next         = pos;
    rsp_valid_next   = rsp_valid && rsp_stall;
    status_next      = status;
    position_next    = position;
    entry_count_next = entry_count;
    req_stall        = (state != S_IDLE);
    ram_we           = 1'b0;
    ram_waddr        = pidx[AW-1:0];
    ram_wdata        = ram_rdata;
    ram_raddr        = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          key_next   = key[KeyWidth-1 -: KW];
          act_next   = action;
          idx_next   = '0;
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_end) begin
          at_next    = scan_at;
          st_next    = ST_NOT_FOUND;
          pos_next   = '0;
          state_next = S_DONE;
          case (act)
            ACT_INSERT: begin
              if (scan_hit) begin
                st_next = ST_DUPLICATE;
              end else if (cnt == CW'(Capacity)) begin
                st_next = ST_FULL;
              end else begin
                st_next    = ST_OK;
                pos_next   = PosWidth'(scan_at);
                idx_next   = cnt;
                state_next = S_INS;
              end
            end
            ACT_REMOVE: begin
              if (scan_hit) begin
                st_next    = ST_OK;
                pos_next   = PosWidth'(scan_at);
                idx_next   = scan_at + CW'(1);
                state_next = S_DEL;
              end
            end
            default: begin
              if (scan_hit) begin
                st_next  = ST_OK;
                pos_next = PosWidth'(scan_at);
              end
            end
          endcase
        end else if (idx < cnt) begin
          pv_next   = 1'b1;
          pidx_next = idx;
          idx_next  = idx_inc;
        end
      end

      S_INS: begin
        ram_we = pv;
        if (idx > at) begin
          ram_raddr = idx_dec[AW-1:0];
          pv_next   = 1'b1;
          pidx_next = idx;
          idx_next  = idx_dec;
        end else if (!pv) begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        ram_we     = 1'b1;
        ram_waddr  = at[AW-1:0];
        ram_wdata  = key_r;
        cnt_next   = cnt + CW'(1);
        state_next = S_DONE;
      end

      S_DEL: begin
        ram_we = pv;
        if (idx < cnt) begin
          pv_next   = 1'b1;
          pidx_next = idx_dec;
          idx_next  = idx_inc;
        end else if (!pv) begin
          cnt_next   = cnt - CW'(1);
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next   = 1'b1;
          status_next      = st;
          position_next    = pos;
          entry_count_next = CountWidth'(cnt);
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/sorted_key_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table: ascending table of distinct packed text keys
// Inserts, removes and searches keys held in one memory in sorted order.
//
//   Channel   Handshake              Fields
//   request   req_valid, req_stall   action, key
//   response  rsp_valid, rsp_stall   status, position, entry_count
//
// One word takes a scan up to the first held key not below the probe, one
// memory read per cycle, then for an insert or remove one moved entry per
// cycle through the same memory. The request side is stalled from acceptance
// until the response word is loaded into the output register. Reset empties
// the table at once.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int CAPACITY  = skt_pkg::CapacityDef,
  parameter int KEY_BYTES = skt_pkg::KeyBytesDef
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [skt_pkg::ActionWidth-1:0] action,
  input  logic [skt_pkg::KeyWidth-1:0]    key,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [skt_pkg::StatusWidth-1:0] status,
  output logic [skt_pkg::PosWidth-1:0]    position,
  output logic [skt_pkg::CountWidth-1:0]  entry_count
);

  import skt_pkg::*;

  localparam int KW = 8 * KEY_BYTES;
  localparam int AW = $clog2(CAPACITY);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [KW-1:0] ram_rdata;
  logic [KW-1:0] probe;
  cmp_res_t      cmp_res;

  skt_ram #(
    .Width(KW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  skt_cmp #(
    .Width(KW)
  ) u_cmp (
    .stored(ram_rdata),
    .probe (probe),
    .res   (cmp_res)
  );

  skt_ctrl #(
    .Capacity(CAPACITY),
    .KeyBytes(KEY_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .key        (key),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .position   (position),
    .entry_count(entry_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .probe      (probe),
    .cmp_res    (cmp_res)
  );

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> req_stall)
    else $error("Table memory written while the block is idle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("Block not busy after accepting a word.");

  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (position == '0))
    else $error("Nonzero position reported with a failure status.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(entry_count) <= CAPACITY))
    else $error("Entry count above capacity.");

endmodule

/* dv/tb_sorted_key_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table: self-checking testbench for the sorted key table
// Runs a directed opening, then phases of fill, drain and mixed request
// words under varying sender and receiver idling. A scoreboard keeps its own
// sorted copy of the table and checks every response word against it.
// ----------------------------------------------------------------------------
module tb_sorted_key_table;
  import skt_pkg::*;

  localparam logic [ActionWidth-1:0] ACT_UNUSED = 2'd3;
  localparam logic [KeyWidth-1:0]    KeyKeep    = {KeyWidth{1'b1}} << (KeyWidth - 8 * KeyBytesDef);
  localparam int KeyPoolSize = 24;
  localparam int NumPhases   = 13;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 4000;
  localparam int TailCycles  = 80;
  localparam int MaxReports  = 50;

  typedef enum {SEQ_FILL, SEQ_MIXED, SEQ_DRAIN} seq_kind_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [PosWidth-1:0]    position;
    logic [CountWidth-1:0]  entry_count;
  } table_result_t;

  class key_table_scoreboard;
    logic [KeyWidth-1:0] held_keys[$];
    table_result_t       expected_results[$];
    int                  mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [KeyWidth-1:0] held_key();
      if (held_keys.size() == 0) return {$urandom, $urandom};
      return held_keys[$urandom_range(held_keys.size() - 1)];
    endfunction

    function table_result_t apply_operation(logic [ActionWidth-1:0] act,
                                            logic [KeyWidth-1:0] raw_key);
      logic [KeyWidth-1:0] k;
      int                  at;
      bit                  hit;
      table_result_t       res;
      k = raw_key & KeyKeep;
      at = 0;
      while (at < held_keys.size() && held_keys[at] < k) at++;
      hit = (at < held_keys.size()) && (held_keys[at] == k);
      res.status = ST_NOT_FOUND;
      res.position = '0;
      case (act)
        ACT_INSERT: begin
          if (hit) begin
            res.status = ST_DUPLICATE;
          end else if (held_keys.size() >= CapacityDef) begin
            res.status = ST_FULL;
          end else begin
            held_keys.insert(at, k);
            res.status = ST_OK;
            res.position = PosWidth'(at);
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            held_keys.delete(at);
            res.status = ST_OK;
            res.position = PosWidth'(at);
          end
        end
        default: begin
          if (hit) begin
            res.status = ST_OK;
            res.position = PosWidth'(at);
          end
        end
      endcase
      res.entry_count = CountWidth'(held_keys.size());
      return res;
    endfunction

    function void note_request(logic [ActionWidth-1:0] act, logic [KeyWidth-1:0] k);
      expected_results.push_back(apply_operation(act, k));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_result(logic [StatusWidth-1:0] st, logic [PosWidth-1:0] pos,
                      logic [CountWidth-1:0] cnt);
      table_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("response word with nothing pending: status %0d", st));
      end else begin
        want = expected_results.pop_front();
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
        if (pos !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d", pos, want.position));
        if (cnt !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", cnt, want.entry_count));
      end
    endtask
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic [ActionWidth-1:0] action    = ACT_INSERT;
  logic [KeyWidth-1:0]    key       = '0;
  logic                   rsp_stall = 1'b0;
  logic                   req_stall;
  logic                   rsp_valid;
  logic [StatusWidth-1:0] status;
  logic [PosWidth-1:0]    position;
  logic [CountWidth-1:0]  entry_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  logic [KeyWidth-1:0] key_pool [KeyPoolSize];
  key_table_scoreboard sb = new();

  sorted_key_table u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .action      (action),
    .key         (key),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HoldCycles;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_request(action, key);
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(status, position, entry_count);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL sorted_key_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [KeyWidth-1:0] text_key(input string s);
    logic [KeyWidth-1:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < KeyBytesDef; i++) v[KeyWidth-1-8*i -: 8] = s[i];
    return v;
  endfunction

  function automatic logic [KeyWidth-1:0] pick_key(input int fresh_pct);
    int r;
    r = $urandom_range(99);
    if (r < fresh_pct) return {$urandom, $urandom};
    if (r < fresh_pct + (100 - fresh_pct) / 2) return key_pool[$urandom_range(KeyPoolSize - 1)];
    return sb.held_key();
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 75;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct <= 75;
      end
      default: begin
        send_idle_pct = 9;
        recv_stall_pct <= 9;
      end
    endcase
  endtask

  task automatic send_request(input logic [ActionWidth-1:0] act, input logic [KeyWidth-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    action    <= act;
    key       <= k;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input seq_kind_t kind, input int count);
    int                     r;
    logic [ActionWidth-1:0] act;
    logic [KeyWidth-1:0]    k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      case (kind)
        SEQ_FILL: begin
          act = (r < 85) ? ACT_INSERT : ((r < 93) ? ACT_SEARCH : ACT_REMOVE);
          k = pick_key(60);
        end
        SEQ_DRAIN: begin
          act = (r < 85) ? ACT_REMOVE : ((r < 95) ? ACT_SEARCH : ACT_UNUSED);
          k = (r < 70) ? sb.held_key() : pick_key(30);
        end
        default: begin
          act = ActionWidth'($urandom_range(3));
          k = pick_key(35);
        end
      endcase
      send_request(act, k);
    end
  endtask

  initial begin
    int                  len;
    logic [KeyWidth-1:0] v;
    seq_kind_t           kind;
    for (int i = 0; i < KeyPoolSize; i++) begin
      len = $urandom_range(1, KeyBytesDef);
      v = '0;
      for (int j = 0; j < len; j++) v[KeyWidth-1-8*j -: 8] = 8'($urandom_range(97, 122));
      key_pool[i] = v;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(IDLE_NONE);
    send_request(ACT_SEARCH, '0);
    send_request(ACT_REMOVE, '1);
    send_request(ACT_INSERT, text_key("mango"));
    send_request(ACT_INSERT, '0);
    send_request(ACT_INSERT, '1);
    send_request(ACT_INSERT, text_key("apple"));
    send_request(ACT_INSERT, text_key("mango"));
    send_request(ACT_INSERT, text_key("mangos"));
    send_request(ACT_SEARCH, text_key("mango"));
    send_request(ACT_UNUSED, '1);
    send_request(ACT_UNUSED, text_key("kiwi"));
    send_request(ACT_SEARCH, text_key("mang"));
    send_request(ACT_REMOVE, text_key("kiwi"));
    send_request(ACT_REMOVE, '0);
    send_request(ACT_REMOVE, '1);
    send_request(ACT_REMOVE, text_key("mango"));
    send_request(ACT_SEARCH, text_key("mangos"));
    send_request(ACT_INSERT, 64'h8000_0000_0000_0000);
    send_request(ACT_INSERT, 64'h0000_0000_0000_0001);
    send_request(ACT_INSERT, text_key("zzzzzzzz"));
    send_request(ACT_SEARCH, 64'h0000_0000_0000_0001);
    wait_for_results();

    for (int phase = 0; phase < NumPhases; phase++) begin
      kind = seq_kind_t'(phase % 3);
      set_idling(idle_mode_t'(phase % 4));
      if (phase % 6 == 1) hold_token <= hold_token + 1;
      run_phase(kind, (kind == SEQ_FILL) ? 55 : 35);
      if (phase % 2 == 1) wait_for_results();
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS sorted_key_table");
    end else begin
      $display("FAIL sorted_key_table");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/skt_cmp.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table.sv
dv/tb_sorted_key_table.sv
